[rtl/texel_format_packer_top_defines.svh]
// Assertion macros shared by the texel format packer checker.
`ifndef TEXEL_FORMAT_PACKER_TOP_DEFINES_SVH
`define TEXEL_FORMAT_PACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TFP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("texel format packer: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("texel format packer: next-cycle check failed");

`endif

[rtl/tfp_pkg.sv]
// Package with the types, codes and quantisation functions of the texel format packer.
package tfp_pkg;

	// Format codes held in the format_mode register.
	localparam logic [2:0] MODE_RGBA32 = 3'd0;
	localparam logic [2:0] MODE_RGB5A3 = 3'd1;
	localparam logic [2:0] MODE_RGB565 = 3'd2;
	localparam logic [2:0] MODE_I8     = 3'd3;
	localparam logic [2:0] MODE_IA4    = 3'd4;

	// Quantisation depths.
	localparam logic [2:0] DEPTH_3 = 3'd3;
	localparam logic [2:0] DEPTH_4 = 3'd4;
	localparam logic [2:0] DEPTH_5 = 3'd5;
	localparam logic [2:0] DEPTH_6 = 3'd6;

	localparam logic [15:0] OPAQUE_BIT    = 16'h8000;
	localparam logic [2:0]  ALPHA3_OPAQUE = 3'd7;

	// Green/blue store of one 4x4 tile.
	localparam int GB_DEPTH = 16;
	localparam int GB_AW    = $clog2(GB_DEPTH);
	localparam int GB_WIDTH = 16;
	localparam logic [GB_AW-1:0] GB_LAST = GB_AW'(GB_DEPTH - 1);

	// Reciprocal of three for sums up to 765: floor(s * 683 / 2048) == floor(s / 3).
	localparam logic [9:0] RECIP3 = 10'd683;
	localparam int RECIP3_SHIFT = 11;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [15:0] packed_word;
		logic        run_end;
	} texel_t;

	// 8-bit level of a code by bit replication.
	function automatic logic [7:0] expand_code(input logic [5:0] code, input logic [2:0] depth);
		logic [7:0] lvl;
		case (depth)
			DEPTH_3: lvl = {code[2:0], code[2:0], code[2:1]};
			DEPTH_4: lvl = {code[3:0], code[3:0]};
			DEPTH_5: lvl = {code[4:0], code[4:2]};
			default: lvl = {code[5:0], code[5:4]};
		endcase
		return lvl;
	endfunction

	// Nearest replicated level; ties go to the smaller code. The candidate with the
	// same top bits as the value is checked against its two neighbours only.
	function automatic logic [5:0] quantize(input logic [7:0] value, input logic [2:0] depth);
		logic [5:0] c0;
		logic [5:0] cmax;
		logic [7:0] l0;
		logic [7:0] lm;
		logic [7:0] lp;
		logic [5:0] best;
		case (depth)
			DEPTH_3: begin
				c0 = {3'd0, value[7:5]};
				cmax = 6'd7;
			end
			DEPTH_4: begin
				c0 = {2'd0, value[7:4]};
				cmax = 6'd15;
			end
			DEPTH_5: begin
				c0 = {1'd0, value[7:3]};
				cmax = 6'd31;
			end
			default: begin
				c0 = value[7:2];
				cmax = 6'd63;
			end
		endcase
		l0 = expand_code(c0, depth);
		lm = expand_code(c0 - 6'd1, depth);
		lp = expand_code(c0 + 6'd1, depth);
		best = c0;
		if (value < l0 && c0 != 6'd0) begin
			if ((value - lm) <= (l0 - value)) begin
				best = c0 - 6'd1;
			end
		end else if (value > l0 && c0 != cmax) begin
			if ((lp - value) < (value - l0)) begin
				best = c0 + 6'd1;
			end
		end
		return best;
	endfunction

	// Intensity (r + g + b) / 3 by a reciprocal multiply.
	function automatic logic [7:0] intensity(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum = {2'd0, r} + {2'd0, g} + {2'd0, b};
		prod = sum * RECIP3;
		return prod[RECIP3_SHIFT+7:RECIP3_SHIFT];
	endfunction

endpackage

[rtl/tfp_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module tfp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/tfp_encoder.sv]
// Pixel register and format encoder of the texel format packer.
module tfp_encoder import tfp_pkg::*; (
	input  logic        clk,
	input  logic        load,
	input  pixel_t      pix,
	input  logic [2:0]  mode,
	output logic [15:0] word
);

	pixel_t pix_s1;

	logic [2:0] a3;
	logic [3:0] a4, r4, g4, b4, i4;
	logic [4:0] r5, g5, b5;
	logic [5:0] g6;
	logic [7:0] inten;
	logic [5:0] q_a3, q_a4, q_r4, q_g4, q_b4, q_i4, q_r5, q_g5, q_b5;

	// Capture the pixel when the transaction is accepted.
	always_ff @(posedge clk) begin
		if (load) begin
			pix_s1 <= pix;
		end
	end

	// Channel quantisers for every depth the formats use.
	always_comb begin
		inten = intensity(pix_s1.red, pix_s1.green, pix_s1.blue);
		q_a3 = quantize(pix_s1.alpha, DEPTH_3);
		q_a4 = quantize(pix_s1.alpha, DEPTH_4);
		q_r4 = quantize(pix_s1.red, DEPTH_4);
		q_g4 = quantize(pix_s1.green, DEPTH_4);
		q_b4 = quantize(pix_s1.blue, DEPTH_4);
		q_i4 = quantize(inten, DEPTH_4);
		q_r5 = quantize(pix_s1.red, DEPTH_5);
		q_g5 = quantize(pix_s1.green, DEPTH_5);
		q_b5 = quantize(pix_s1.blue, DEPTH_5);
		g6 = quantize(pix_s1.green, DEPTH_6);
		a3 = q_a3[2:0];
		a4 = q_a4[3:0];
		r4 = q_r4[3:0];
		g4 = q_g4[3:0];
		b4 = q_b4[3:0];
		i4 = q_i4[3:0];
		r5 = q_r5[4:0];
		g5 = q_g5[4:0];
		b5 = q_b5[4:0];
	end

	// Format selection.
	always_comb begin
		unique case (mode)
			MODE_RGBA32: word = {pix_s1.alpha, pix_s1.red};
			MODE_RGB5A3: begin
				if (a3 < ALPHA3_OPAQUE) begin
					word = {1'b0, a3, r4, g4, b4};
				end else begin
					word = OPAQUE_BIT | {1'b0, r5, g5, b5};
				end
			end
			MODE_RGB565: word = {r5, g6, b5};
			MODE_I8:     word = {8'd0, inten};
			MODE_IA4:    word = {8'd0, a4, i4};
			default:     word = 16'd0;
		endcase
	end

endmodule

[rtl/texel_format_packer_top.sv]
// Top level of the texel format packer: control, tile store and output register.
//
// One pixel transaction is accepted, then encoded into the output register, after which
// the next pixel may be accepted. In RGBA32 mode the green/blue halves go into a
// 16-entry store RAM; the sixteenth pixel of a tile adds a flush (a read set-up, then
// one stored word per cycle through the RAM's single read port while the output is
// not stalled), during which no pixel is accepted. Stalls on the output also hold the
// encode step. Codes 5 to 7 in format_mode give no texel for a pixel.
module texel_format_packer_top import tfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  pixel_t     pix,
	output logic       tex_valid,
	input  logic       tex_ready,
	output texel_t     tex,
	input  logic       cfg_we,
	input  logic [2:0] cfg_data
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_ENC     = 2'd1;
	localparam logic [1:0] ST_FL_READ = 2'd2;
	localparam logic [1:0] ST_FL_EMIT = 2'd3;

	logic [1:0]       state_q;
	logic [2:0]       format_mode_q;
	logic [GB_AW-1:0] tile_slot_q;
	logic [GB_AW-1:0] rd_idx_q;
	logic             flush_q;
	logic             tex_valid_q;
	texel_t           tex_q;

	logic             accept;
	logic             out_free;
	logic             load_enc;
	logic             load_fl;
	logic             gb_we;
	logic             gb_re;
	logic [GB_AW-1:0] gb_raddr;
	logic [15:0]      gb_rdata;
	logic [15:0]      enc_word;
	logic             mode_rgba32;
	logic             mode_known;

	assign pix_ready   = (state_q == ST_IDLE);
	assign accept      = pix_valid && pix_ready;
	assign out_free    = !tex_valid_q || tex_ready;
	assign mode_rgba32 = (format_mode_q == MODE_RGBA32);
	assign mode_known  = (format_mode_q <= MODE_IA4);
	assign load_enc    = (state_q == ST_ENC) && mode_known && out_free;
	assign load_fl     = (state_q == ST_FL_EMIT) && out_free;
	assign gb_we       = accept && mode_rgba32;

	// Stored words are read ahead so that one leaves per cycle during a flush while the output is not stalled.
	assign gb_re    = (state_q == ST_FL_READ) || (load_fl && rd_idx_q != GB_LAST);
	assign gb_raddr = (state_q == ST_FL_READ) ? rd_idx_q : rd_idx_q + GB_AW'(1);

	tfp_encoder u_enc (
		.clk  (clk),
		.load (accept),
		.pix  (pix),
		.mode (format_mode_q),
		.word (enc_word)
	);

	tfp_ram #(
		.WIDTH (GB_WIDTH),
		.DEPTH (GB_DEPTH)
	) u_gb_ram (
		.clk   (clk),
		.we    (gb_we),
		.waddr (tile_slot_q),
		.wdata ({pix.green, pix.blue}),
		.re    (gb_re),
		.raddr (gb_raddr),
		.rdata (gb_rdata)
	);

	// Format register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= MODE_RGBA32;
		end else if (cfg_we) begin
			format_mode_q <= cfg_data;
		end
	end

	// Sequencer: encode one pixel, then flush the tile store when the tile is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tile_slot_q <= '0;
			rd_idx_q    <= '0;
			flush_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ENC;
						flush_q <= mode_rgba32 && (tile_slot_q == GB_LAST);
						if (mode_rgba32) begin
							tile_slot_q <= tile_slot_q + GB_AW'(1);
						end
					end
				end
				ST_ENC: begin
					if (!mode_known) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						rd_idx_q <= '0;
						state_q  <= (mode_rgba32 && flush_q) ? ST_FL_READ : ST_IDLE;
					end
				end
				ST_FL_READ: begin
					state_q <= ST_FL_EMIT;
				end
				ST_FL_EMIT: begin
					if (out_free) begin
						if (rd_idx_q == GB_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + GB_AW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_valid_q <= 1'b0;
		end else if (load_enc || load_fl) begin
			tex_valid_q <= 1'b1;
		end else if (tex_ready) begin
			tex_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_enc) begin
			tex_q.packed_word <= enc_word;
			tex_q.run_end     <= !(mode_rgba32 && flush_q);
		end else if (load_fl) begin
			tex_q.packed_word <= gb_rdata;
			tex_q.run_end     <= (rd_idx_q == GB_LAST);
		end
	end

	assign tex_valid = tex_valid_q;
	assign tex       = tex_q;

endmodule

[rtl/tfp_checker.sv]
// Port-level checker of the texel format packer, bound to the top level.
`include "texel_format_packer_top_defines.svh"

module tfp_checker import tfp_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   pix_valid,
	input logic   pix_ready,
	input logic   tex_valid,
	input logic   tex_ready,
	input texel_t tex
);

	// A stalled texel transaction holds its payload.
	`TFP_ASSERT_NEXT(a_tex_hold, tex_valid && !tex_ready, tex_valid && $stable(tex))

	// A pixel is worked on alone: no second pixel is taken in the next cycle.
	`TFP_ASSERT_NEXT(a_one_pixel, pix_valid && pix_ready, !pix_ready)

	// While a tile flush is still running no pixel is taken.
	`TFP_ASSERT_NOW(a_run_busy, tex_valid && tex_ready && !tex.run_end, !pix_ready)

	// A pixel accepted now cannot have produced a texel in the same cycle's register load.
	`TFP_ASSERT_NEXT(a_no_early_out, pix_valid && pix_ready && !tex_valid, !tex_valid)

endmodule

bind texel_format_packer_top tfp_checker u_tfp_checker (.*);

[bench/texel_format_packer_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts the texel transactions of the texel format packer and compares them.
module texel_format_packer_checker import tfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	input  logic        pix_ready,
	input  pixel_t      pix,
	input  logic        tex_valid,
	input  logic        tex_ready,
	input  texel_t      tex,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	output int unsigned mismatch_count,
	output int unsigned pending_count
);

	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned TILE_TEXELS = 16;
	localparam logic [3:0] LAST_TILE_SLOT = 4'd15;

	logic [2:0]  format_shadow;
	logic [3:0]  tile_slot_shadow;
	logic [15:0] green_blue_shadow [TILE_TEXELS];
	texel_t      expected_texels [$];
	int unsigned mismatches;

	// The 8-bit level of a code, made by repeating its bits from the top downwards.
	function automatic int unsigned replicated_level(input int unsigned code,
			input int unsigned depth);
		int unsigned acc;
		int unsigned filled;
		acc = 0;
		filled = 0;
		while (filled < 8) begin
			acc = (acc << depth) | code;
			filled += depth;
		end
		return (acc >> (filled - 8)) & 8'hFF;
	endfunction

	// Searches every code for the nearest level; a strict compare keeps the smaller code on a tie.
	function automatic int unsigned nearest_code(input int unsigned value,
			input int unsigned depth);
		int unsigned best;
		int unsigned best_err;
		int unsigned err;
		int unsigned lvl;
		best = 0;
		best_err = 1000;
		for (int unsigned c = 0; c < (1 << depth); c++) begin
			lvl = replicated_level(c, depth);
			err = (lvl > value) ? lvl - value : value - lvl;
			if (err < best_err) begin
				best_err = err;
				best = c;
			end
		end
		return best;
	endfunction

	// Works out the texels that one accepted pixel causes and queues them in order.
	task automatic predict_texels(input pixel_t p);
		int unsigned word;
		int unsigned alpha_code;
		int unsigned grey;
		logic        has_word;
		texel_t      t;
		grey = (p.red + p.green + p.blue) / 3;
		has_word = 1'b1;
		word = 0;
		case (format_shadow)
			MODE_RGBA32: begin
				has_word = 1'b0;
				green_blue_shadow[tile_slot_shadow] = {p.green, p.blue};
				t.packed_word = {p.alpha, p.red};
				t.run_end = (tile_slot_shadow != LAST_TILE_SLOT);
				expected_texels.push_back(t);
				if (tile_slot_shadow == LAST_TILE_SLOT) begin
					// The tile is complete, so every stored green/blue word follows.
					for (int unsigned i = 0; i < TILE_TEXELS; i++) begin
						t.packed_word = green_blue_shadow[i];
						t.run_end = (i == TILE_TEXELS - 1);
						expected_texels.push_back(t);
					end
					tile_slot_shadow = '0;
				end else begin
					tile_slot_shadow = tile_slot_shadow + 4'd1;
				end
			end
			MODE_RGB5A3: begin
				alpha_code = nearest_code(p.alpha, 3);
				if (alpha_code < ALPHA3_OPAQUE) begin
					word = (alpha_code << 12) | (nearest_code(p.red, 4) << 8) |
						(nearest_code(p.green, 4) << 4) | nearest_code(p.blue, 4);
				end else begin
					word = OPAQUE_BIT | (nearest_code(p.red, 5) << 10) |
						(nearest_code(p.green, 5) << 5) | nearest_code(p.blue, 5);
				end
			end
			MODE_RGB565: begin
				word = (nearest_code(p.red, 5) << 11) | (nearest_code(p.green, 6) << 5) |
					nearest_code(p.blue, 5);
			end
			MODE_I8: begin
				word = grey;
			end
			MODE_IA4: begin
				word = (nearest_code(p.alpha, 4) << 4) | nearest_code(grey, 4);
			end
			default: begin
				// The unused codes give no texel and leave the tile alone.
				has_word = 1'b0;
			end
		endcase
		if (has_word) begin
			t.packed_word = word[15:0];
			t.run_end = 1'b1;
			expected_texels.push_back(t);
		end
	endtask

	// Each edge: check the texel transaction, then predict from the pixel transaction.
	always @(posedge clk or negedge arst_n) begin
		texel_t expected;
		if (!arst_n) begin
			format_shadow = MODE_RGBA32;
			tile_slot_shadow = '0;
			expected_texels.delete();
			mismatches = 0;
		end else begin
			if (tex_valid && tex_ready) begin
				if (expected_texels.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("texel with nothing expected: word %h end %b",
							tex.packed_word, tex.run_end);
					end
				end else begin
					expected = expected_texels.pop_front();
					if (tex.packed_word !== expected.packed_word ||
							tex.run_end !== expected.run_end) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("texel mismatch: expected word %h end %b, got word %h end %b",
								expected.packed_word, expected.run_end,
								tex.packed_word, tex.run_end);
						end
					end
				end
			end
			if (pix_valid && pix_ready) begin
				predict_texels(pix);
			end
			if (cfg_we) begin
				format_shadow = cfg_data;
			end
		end
		mismatch_count <= mismatches;
		pending_count <= expected_texels.size();
	end

endmodule

[bench/tb_texel_format_packer_top.sv]
`timescale 1ns / 100ps
// Testbench top of the texel format packer: clock, reset, stimulus, watchdog and verdict.
module tb_texel_format_packer_top;
	import tfp_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned END_CYCLES = 30;
	localparam int unsigned PHASE_PIXELS = 28;
	localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_ready;
	pixel_t      pix = '0;
	logic        tex_valid;
	logic        tex_ready = 1'b0;
	texel_t      tex;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_data = MODE_RGBA32;
	int unsigned mismatch_count;
	int unsigned pending_count;
	int unsigned send_idle_pct = 30;
	int unsigned recv_idle_pct = 80;
	int unsigned stall_cycles = 0;

	texel_format_packer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.tex_valid (tex_valid),
		.tex_ready (tex_ready),
		.tex       (tex),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	texel_format_packer_checker u_texel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix_valid      (pix_valid),
		.pix_ready      (pix_ready),
		.pix            (pix),
		.tex_valid      (tex_valid),
		.tex_ready      (tex_ready),
		.tex            (tex),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// A 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver stalls at random with the current idle percentage.
	always @(posedge clk) begin
		tex_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// The watchdog ends the run after too many cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (tex_valid && tex_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_texel_format_packer_top: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offers one pixel after a random gap and holds it until the transaction completes.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= '{red: r, green: g, blue: b, alpha: a};
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
	endtask

	// Channel values lean towards the extremes now and then.
	function automatic logic [7:0] random_channel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_random_pixel();
		send_pixel(random_channel(), random_channel(), random_channel(), random_channel());
	endtask

	// Holds the pixels back until every texel is out and the block has settled, then
	// writes the format register.
	task automatic set_format(input logic [2:0] mode);
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Bursts of pixels in randomly chosen formats; RGBA32 is favoured so that tiles complete.
	task automatic run_random_phase(input int unsigned sender_pct, input int unsigned receiver_pct);
		int unsigned sent;
		int unsigned burst;
		int unsigned pick;
		logic [2:0]  mode;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		sent = 0;
		while (sent < PHASE_PIXELS) begin
			pick = $urandom_range(19);
			if (pick < 8) begin
				mode = MODE_RGBA32;
			end else if (pick < 11) begin
				mode = MODE_RGB5A3;
			end else if (pick < 14) begin
				mode = MODE_RGB565;
			end else if (pick < 16) begin
				mode = MODE_I8;
			end else if (pick < 18) begin
				mode = MODE_IA4;
			end else begin
				mode = 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
			end
			set_format(mode);
			if (mode == MODE_RGBA32) begin
				burst = $urandom_range(20, 1);
			end else if (mode >= MODE_UNUSED_FIRST) begin
				burst = $urandom_range(3, 1);
			end else begin
				burst = $urandom_range(10, 2);
			end
			repeat (burst) send_random_pixel();
			if (mode < MODE_UNUSED_FIRST) begin
				sent += burst;
			end
		end
	endtask

	// Reset, directed pixels, three random phases, then the drain and the verdict.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// RGB5A3: extremes, the alpha tie between the top two codes, and channel ties.
		set_format(MODE_RGB5A3);
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'd12, 8'd6, 8'd18, 8'd237);
		send_pixel(8'd12, 8'd6, 8'd18, 8'd238);
		send_pixel(8'h80, 8'h7F, 8'h01, 8'd18);

		// RGB565 with the 5-bit and 6-bit ties.
		set_format(MODE_RGB565);
		send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		send_pixel(8'd12, 8'd6, 8'hFF, 8'h00);

		// I8 at the largest and smallest sums.
		set_format(MODE_I8);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h01, 8'h01, 8'h00, 8'hFF);
		send_pixel(8'hAA, 8'h55, 8'h00, 8'h00);

		set_format(MODE_IA4);
		send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);

		// The unused codes swallow the pixel.
		for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
			set_format(3'(m));
			send_random_pixel();
		end

		// A tile interrupted by another format, which resumes in the random part.
		set_format(MODE_RGBA32);
		repeat (6) send_random_pixel();
		set_format(MODE_I8);
		send_random_pixel();
		set_format(MODE_RGBA32);
		repeat (3) send_random_pixel();

		run_random_phase(30, 80);
		run_random_phase(80, 30);
		run_random_phase(0, 0);

		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("tb_texel_format_packer_top: PASS");
		end else begin
			$display("tb_texel_format_packer_top: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/tfp_pkg.sv
rtl/tfp_ram.sv
rtl/tfp_encoder.sv
rtl/texel_format_packer_top.sv
rtl/tfp_checker.sv
bench/texel_format_packer_checker.sv
bench/tb_texel_format_packer_top.sv
